// ===== rtl/core/rtpl_pkg.sv =====
// Shared types and constants for the route table priority lookup.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package rtpl_pkg;

	// Number of table entries and the width of an index that walks them.
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Field widths fixed by the item format.
	localparam int SLOT_W = 4;
	localparam int KIND_W = 2;
	localparam int SEL_W  = 16;

	// Entry and match kinds.
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONTRACT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADDRESS  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DEFAULT  = 2'd3;

	// Item modes carried on the input tuser.
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;       // write the entry carried by the accepted item
		logic start;    // latch the query and clear the scan results
		logic step;     // evaluate the entry at the scan index
		logic load_out; // move the scan result into the output register
	} rtpl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic con_hit;  // the entry under evaluation is a contract match
		logic last;     // the scan index is at the last entry
		logic out_free; // the output register can take a result
	} rtpl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rtpl_ctrl.sv =====
// Controller state machine for the route table lookup.
// Depends on rtpl_pkg; drives the datapath rtpl_dp through command and status structs.
`default_nettype none
module rtpl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_mode,
	output logic                   in_ready,
	input  wire rtpl_pkg::rtpl_sts_t sts,
	output rtpl_pkg::rtpl_cmd_t    cmd
);
	import rtpl_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// Items are taken only between lookups.
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_mode == MODE_LOOKUP) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.con_hit || sts.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rtpl_dp.sv =====
// Datapath of the route table lookup: entry storage, scan unit and output register.
// Depends on rtpl_pkg; sequenced by rtpl_ctrl.
`default_nettype none
module rtpl_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rtpl_pkg::rtpl_cmd_t          cmd,
	output rtpl_pkg::rtpl_sts_t               sts,
	input  wire logic [rtpl_pkg::SLOT_W-1:0]  entry_slot,
	input  wire logic                         entry_valid,
	input  wire logic [rtpl_pkg::KIND_W-1:0]  entry_kind,
	input  wire logic [rtpl_pkg::SEL_W-1:0]   entry_selector,
	input  wire logic [rtpl_pkg::SEL_W-1:0]   query_contract,
	input  wire logic [rtpl_pkg::SEL_W-1:0]   query_dest,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic                              hit,
	output logic [rtpl_pkg::KIND_W-1:0]       match_kind,
	output logic [rtpl_pkg::SLOT_W-1:0]       route_slot
);
	import rtpl_pkg::*;

	// Table storage: valid bits are reset, kind and selector are not.
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KIND_W-1:0]        kind_q [TABLE_ENTRIES];
	logic [SEL_W-1:0]         sel_q  [TABLE_ENTRIES];

	// Scan state.
	logic [IDX_W-1:0]  idx_q;
	logic [SEL_W-1:0]  qc_q;
	logic [SEL_W-1:0]  qd_q;
	logic              have_con_q;
	logic              have_addr_q;
	logic              have_def_q;
	logic [IDX_W-1:0]  con_slot_q;
	logic [IDX_W-1:0]  addr_slot_q;
	logic [IDX_W-1:0]  def_slot_q;

	logic              wr_in_range;
	logic [IDX_W-1:0]  wr_idx;
	logic              cur_valid;
	logic [KIND_W-1:0] cur_kind;
	logic [SEL_W-1:0]  cur_sel;
	logic              con_match;
	logic              addr_match;
	logic              def_match;

	assign wr_in_range = (32'(entry_slot) < 32'(TABLE_ENTRIES));
	assign wr_idx      = IDX_W'(entry_slot);

	// Entry writes; a slot beyond the table is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr && wr_in_range) begin
			valid_q[wr_idx] <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			kind_q[wr_idx] <= entry_kind;
			sel_q[wr_idx]  <= entry_selector;
		end
	end

	// Evaluate the entry at the scan index.
	assign cur_valid  = valid_q[idx_q];
	assign cur_kind   = kind_q[idx_q];
	assign cur_sel    = sel_q[idx_q];
	assign con_match  = cur_valid && (cur_kind == KIND_CONTRACT) && (cur_sel == qc_q);
	assign addr_match = cur_valid && (cur_kind == KIND_ADDRESS) && (cur_sel == qd_q);
	assign def_match  = cur_valid && (cur_kind == KIND_DEFAULT);

	assign sts.con_hit  = con_match;
	assign sts.last     = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign sts.out_free = !out_valid || out_ready;

	// Scan flags and index; later address and default matches overwrite earlier ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			have_con_q  <= 1'b0;
			have_addr_q <= 1'b0;
			have_def_q  <= 1'b0;
		end else if (cmd.start) begin
			idx_q       <= '0;
			have_con_q  <= 1'b0;
			have_addr_q <= 1'b0;
			have_def_q  <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (con_match) begin
				have_con_q <= 1'b1;
			end else if (addr_match) begin
				have_addr_q <= 1'b1;
			end else if (def_match) begin
				have_def_q <= 1'b1;
			end
		end
	end

	// Query and slot payload registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qc_q <= query_contract;
			qd_q <= query_dest;
		end
		if (cmd.step) begin
			if (con_match) begin
				con_slot_q <= idx_q;
			end else if (addr_match) begin
				addr_slot_q <= idx_q;
			end else if (def_match) begin
				def_slot_q <= idx_q;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result selection by priority: contract, then address, then default.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			priority if (have_con_q) begin
				hit        <= 1'b1;
				match_kind <= KIND_CONTRACT;
				route_slot <= SLOT_W'(con_slot_q);
			end else if (have_addr_q) begin
				hit        <= 1'b1;
				match_kind <= KIND_ADDRESS;
				route_slot <= SLOT_W'(addr_slot_q);
			end else if (have_def_q) begin
				hit        <= 1'b1;
				match_kind <= KIND_DEFAULT;
				route_slot <= SLOT_W'(def_slot_q);
			end else begin
				hit        <= 1'b0;
				match_kind <= KIND_NONE;
				route_slot <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/route_table_priority_lookup_top.sv =====
// Route table priority lookup, top level: stream ports, controller and datapath.
// Depends on rtpl_pkg, rtpl_ctrl and rtpl_dp.
// A write item gives no result and leaves the controller idle.
// A lookup scans the table at one table entry per cycle in the scan unit, stopping early on a
// contract match, then loads the result into the output register once that register is free;
// no new item is taken until then. The result register frees the input side.
// Reset clears all valid bits, the controller and the output valid flag at once.
`default_nettype none
module route_table_priority_lookup_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata from bit 0: entry_slot[3:0], entry_valid[4], entry_kind[6:5],
	// entry_selector[22:7], query_contract[38:23], query_dest[54:39], zero[55]
	input  wire logic [55:0] s_tdata,
	// tuser: mode[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata from bit 0: hit[0], route_slot[4:1], zero[7:5]
	output logic [7:0]       m_tdata,
	// tuser: match_kind[1:0]
	output logic [1:0]       m_tuser
);
	import rtpl_pkg::*;

	rtpl_cmd_t         cmd;
	rtpl_sts_t         sts;
	logic              hit;
	logic [KIND_W-1:0] match_kind;
	logic [SLOT_W-1:0] route_slot;

	// Sequencing of writes and lookups.
	rtpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, scan unit and result register.
	rtpl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.entry_slot     (s_tdata[3:0]),
		.entry_valid    (s_tdata[4]),
		.entry_kind     (s_tdata[6:5]),
		.entry_selector (s_tdata[22:7]),
		.query_contract (s_tdata[38:23]),
		.query_dest     (s_tdata[54:39]),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.hit            (hit),
		.match_kind     (match_kind),
		.route_slot     (route_slot)
	);

	// Result packing.
	assign m_tdata = {3'b000, route_slot, hit};
	assign m_tuser = match_kind;

endmodule
`default_nettype wire
